// File: rtl/rmed_pkg.sv
// shared constants and types for the rgb temporal median block
`default_nettype none
package rmed_pkg;

   // number of frames and width of one colour channel
   localparam int FRAME_COUNT  = 9;
   localparam int CHANNEL_BITS = 8;

   // fixed word layout
   localparam int INPUT_FIELDS = 9;
   localparam int PIXEL_BITS   = 24;
   localparam int CHANNELS     = 3;
   localparam int REQ_BITS     = INPUT_FIELDS * PIXEL_BITS;
   localparam int REQ_BYTES    = (REQ_BITS + 7) / 8;
   localparam int REQ_WIDTH    = REQ_BYTES * 8;
   localparam int RSP_WIDTH    = ((PIXEL_BITS + 7) / 8) * 8;

   // frames that take part and the selected rank
   localparam int FRAMES_USED  = (FRAME_COUNT > INPUT_FIELDS) ? INPUT_FIELDS : FRAME_COUNT;
   localparam int MID_RANK     = FRAMES_USED / 2;
   localparam int RANK_BITS    = $clog2(FRAMES_USED + 1);

   typedef logic [CHANNEL_BITS-1:0] chan_type;

   // stage load strobes from the flow control to the lanes
   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic out_load;
   } pipe_ctrl_type;

endpackage
`default_nettype wire

// File: rtl/rmed_flow.sv
// valid tracking and stall control for the three-stage pipeline
`default_nettype none
module rmed_flow (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output rmed_pkg::pipe_ctrl_type ctrl
);

   logic s1_v_ff, s2_v_ff, out_v_ff;
   logic s1_v_in, s2_v_in, out_v_in;

   // a stage loads when it is empty or its word moves on
   always_comb begin
      ctrl.out_load = !out_v_ff || rsp_tready;
      ctrl.s2_load  = !s2_v_ff  || ctrl.out_load;
      ctrl.s1_load  = !s1_v_ff  || ctrl.s2_load;
   end

   assign req_tready = ctrl.s1_load;
   assign rsp_tvalid = out_v_ff;

   // next valid bits
   always_comb begin
      s1_v_in  = ctrl.s1_load  ? req_tvalid : s1_v_ff;
      s2_v_in  = ctrl.s2_load  ? s1_v_ff    : s2_v_ff;
      out_v_in = ctrl.out_load ? s2_v_ff    : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/rmed_lane.sv
// one channel lane: pairwise compare stage, then rank count and select stage
`default_nettype none
module rmed_lane (
   input  wire                     clock,
   input  rmed_pkg::pipe_ctrl_type ctrl,
   input  rmed_pkg::chan_type      chan [rmed_pkg::FRAMES_USED],
   output rmed_pkg::chan_type      median
);

   localparam int N = rmed_pkg::FRAMES_USED;

   rmed_pkg::chan_type v_ff [N];
   logic               pre_ff [N][N];
   logic               pre_in [N][N];
   rmed_pkg::chan_type median_ff;
   rmed_pkg::chan_type median_in;

   // pre[i][j]: value j comes before value i in a stable ascending order
   always_comb begin
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N; j++) begin
            pre_in[i][j] = (chan[j] < chan[i]) || ((chan[j] == chan[i]) && (j < i));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         for (int i = 0; i < N; i++) begin
            v_ff[i] <= chan[i];
            for (int j = 0; j < N; j++) begin
               pre_ff[i][j] <= pre_in[i][j];
            end
         end
      end
   end

   // ranks form a permutation, so exactly one value sits at the middle rank
   always_comb begin
      logic [rmed_pkg::RANK_BITS-1:0] rank;
      median_in = '0;
      for (int i = 0; i < N; i++) begin
         rank = '0;
         for (int j = 0; j < N; j++) begin
            rank = rank + rmed_pkg::RANK_BITS'(pre_ff[i][j]);
         end
         if (rank == rmed_pkg::RANK_BITS'(rmed_pkg::MID_RANK)) begin
            median_in = median_in | v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s2_load) begin
         median_ff <= median_in;
      end
   end

   assign median = median_ff;

endmodule
`default_nettype wire

// File: rtl/rgb_median_of_nine_frames.sv
// An accepted req word passes the compare, count-and-select and output registers to its rsp word.
// Throughput: one word per cycle; req and rsp each see one word a cycle
// while rsp_tready holds high. Three lanes (red, green, blue) each rank
// all frame values in one compare stage and one count-and-select stage.
// Reset clears the stage valid bits only; the datapath registers are not reset.
`default_nettype none
module rgb_median_of_nine_frames (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   // frame0_pixel [23:0], frame1_pixel [47:24] ... frame8_pixel [215:192]
   input  wire  [rmed_pkg::REQ_WIDTH-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // median_pixel [23:0]
   output logic [rmed_pkg::RSP_WIDTH-1:0] rsp_tdata
);

   localparam int N  = rmed_pkg::FRAMES_USED;
   localparam int CB = rmed_pkg::CHANNEL_BITS;

   rmed_pkg::pipe_ctrl_type ctrl;
   rmed_pkg::chan_type      lane_in  [rmed_pkg::CHANNELS][N];
   rmed_pkg::chan_type      lane_out [rmed_pkg::CHANNELS];
   logic [rmed_pkg::PIXEL_BITS-1:0] pixel_ff;
   logic [rmed_pkg::PIXEL_BITS-1:0] pixel_in;

   rmed_flow u_flow (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   // split each frame pixel into its channels, blue lowest
   always_comb begin
      for (int c = 0; c < rmed_pkg::CHANNELS; c++) begin
         for (int f = 0; f < N; f++) begin
            lane_in[c][f] = req_tdata[f*rmed_pkg::PIXEL_BITS + c*CB +: CB];
         end
      end
   end

   for (genvar c = 0; c < rmed_pkg::CHANNELS; c++) begin : g_lane
      rmed_lane u_lane (
         .clock  (clock),
         .ctrl   (ctrl),
         .chan   (lane_in[c]),
         .median (lane_out[c])
      );
   end

   // merge the three channel medians into one pixel
   always_comb begin
      pixel_in = '0;
      for (int c = 0; c < rmed_pkg::CHANNELS; c++) begin
         pixel_in[c*CB +: CB] = lane_out[c];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         pixel_ff <= pixel_in;
      end
   end

   assign rsp_tdata = rmed_pkg::RSP_WIDTH'(pixel_ff);

endmodule
`default_nettype wire
